>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int SLOTS   = 32;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int HASH_W  = 32;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_LIVE  = 2'd1;
   localparam logic [1:0] KIND_TOMB  = 2'd2;

   localparam logic [1:0] CMD_SET    = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [2:0] ST_UPDATED   = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // Write port of the slot store.
   typedef struct packed {
      logic               kind_we;
      logic               entry_we;
      logic [IDX_W-1:0]   idx;
      logic [1:0]         kind;
      logic [HASH_W-1:0]  hash;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } wr_type;

   // Read data of the slot store, registered from the read address.
   typedef struct packed {
      logic [1:0]         kind;
      logic [HASH_W-1:0]  hash;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [VALUE_W-1:0] read_value;
      logic [CNT_W-1:0]   live_count;
   } res_type;

endpackage

>>> design/lpht_slot_store.sv
// ----------------------------------------------------------------------------
// lpht_slot_store
// Slot kind memory with per-slot valid bits, and the hash/key/value memory.
// One read port and one write port, read data registered.
// ----------------------------------------------------------------------------
module lpht_slot_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lpht_pkg::IDX_W-1:0]    rd_addr,
   input  lpht_pkg::wr_type              wr,
   output lpht_pkg::slot_type            rd
);

   logic [1:0]                    kind_mem [lpht_pkg::SLOTS];
   logic [lpht_pkg::HASH_W-1:0]   hash_mem [lpht_pkg::SLOTS];
   logic [lpht_pkg::KEY_W-1:0]    key_mem [lpht_pkg::SLOTS];
   logic [lpht_pkg::VALUE_W-1:0]  value_mem [lpht_pkg::SLOTS];
   logic [lpht_pkg::SLOTS-1:0]    valid_ff;
   logic                          rd_valid_ff;
   logic [1:0]                    rd_kind_ff;
   logic [lpht_pkg::HASH_W-1:0]   rd_hash_ff;
   logic [lpht_pkg::KEY_W-1:0]    rd_key_ff;
   logic [lpht_pkg::VALUE_W-1:0]  rd_value_ff;

   // A slot never written since reset reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.kind_we) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.kind_we) begin
         kind_mem[wr.idx] <= wr.kind;
      end
      rd_kind_ff  <= kind_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.entry_we) begin
         hash_mem[wr.idx]  <= wr.hash;
         key_mem[wr.idx]   <= wr.key;
         value_mem[wr.idx] <= wr.value;
      end
      rd_hash_ff  <= hash_mem[rd_addr];
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   always_comb begin
      rd.kind  = rd_valid_ff ? rd_kind_ff : lpht_pkg::KIND_EMPTY;
      rd.hash  = rd_hash_ff;
      rd.key   = rd_key_ff;
      rd.value = rd_value_ff;
   end

endmodule

>>> design/lpht_probe_fsm.sv
// ----------------------------------------------------------------------------
// lpht_probe_fsm
// Probe sequencer: walks the slots one per cycle from the start slot, notes
// the first free slot, then commits the update and hands out the result.
// ----------------------------------------------------------------------------
module lpht_probe_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [lpht_pkg::HASH_W-1:0]   req_hash,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key,
   input  logic [lpht_pkg::VALUE_W-1:0]  req_value,
   input  lpht_pkg::slot_type            rd,
   output logic [lpht_pkg::IDX_W-1:0]    rd_addr,
   output lpht_pkg::wr_type              wr,
   output logic                          res_valid,
   input  logic                          res_ready,
   output lpht_pkg::res_type             res
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PROBE  = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   localparam logic [lpht_pkg::IDX_W-1:0] LAST_IDX = lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1);

   logic [1:0]                    state_ff, state_in;
   logic [1:0]                    cmd_ff, cmd_in;
   logic [lpht_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [lpht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lpht_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [lpht_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [lpht_pkg::IDX_W-1:0]    steps_ff, steps_in;
   logic                          free_vld_ff, free_vld_in;
   logic [lpht_pkg::IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                          hit_ff, hit_in;
   logic [lpht_pkg::VALUE_W-1:0]  hit_value_ff, hit_value_in;
   logic [lpht_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [lpht_pkg::IDX_W-1:0]    next_idx;
   logic                          match;

   assign next_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign match = (rd.kind == lpht_pkg::KIND_LIVE) && (rd.hash == hash_ff)
                  && (rd.key == key_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      steps_in     = steps_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      hit_in       = hit_ff;
      hit_value_in = hit_value_ff;
      count_in     = count_ff;
      rd_addr      = idx_ff;
      wr           = '0;
      res_valid    = 1'b0;
      res          = '0;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_hash[lpht_pkg::IDX_W-1:0];
            if (req_valid) begin
               cmd_in      = req_cmd;
               hash_in     = req_hash;
               key_in      = req_key;
               value_in    = req_value;
               idx_in      = req_hash[lpht_pkg::IDX_W-1:0];
               steps_in    = '0;
               free_vld_in = 1'b0;
               hit_in      = 1'b0;
               state_in    = (req_cmd == lpht_pkg::CMD_SET || req_cmd == lpht_pkg::CMD_LOOKUP
                              || req_cmd == lpht_pkg::CMD_DELETE) ? S_PROBE : S_FINISH;
            end
         end

         S_PROBE: begin
            if (rd.kind == lpht_pkg::KIND_EMPTY) begin
               if (!free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = idx_ff;
               end
               state_in = S_FINISH;
            end else if (match) begin
               hit_in       = 1'b1;
               hit_value_in = rd.value;
               state_in     = S_FINISH;
            end else begin
               if (rd.kind != lpht_pkg::KIND_LIVE && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (steps_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = next_idx;
                  steps_in = steps_ff + 1'b1;
                  rd_addr  = next_idx;
               end
            end
         end

         S_FINISH: begin
            res_valid      = 1'b1;
            res.status     = lpht_pkg::ST_NOT_FOUND;
            res.live_count = count_ff;
            wr.hash        = hash_ff;
            wr.key         = key_ff;
            wr.value       = value_ff;
            wr.idx         = idx_ff;
            unique case (cmd_ff)
               lpht_pkg::CMD_SET: begin
                  if (hit_ff) begin
                     res.status  = lpht_pkg::ST_UPDATED;
                     wr.entry_we = res_ready;
                  end else if (free_vld_ff) begin
                     res.status     = lpht_pkg::ST_INSERTED;
                     res.live_count = count_ff + 1'b1;
                     wr.idx         = free_idx_ff;
                     wr.kind        = lpht_pkg::KIND_LIVE;
                     wr.kind_we     = res_ready;
                     wr.entry_we    = res_ready;
                  end else begin
                     res.status = lpht_pkg::ST_FULL;
                  end
               end
               lpht_pkg::CMD_LOOKUP: begin
                  if (hit_ff) begin
                     res.status     = lpht_pkg::ST_FOUND;
                     res.read_value = hit_value_ff;
                  end
               end
               lpht_pkg::CMD_DELETE: begin
                  if (hit_ff) begin
                     res.status = lpht_pkg::ST_FOUND;
                     if (count_ff != '0) begin
                        res.live_count = count_ff - 1'b1;
                     end
                     wr.kind    = lpht_pkg::KIND_TOMB;
                     wr.kind_we = res_ready;
                  end
               end
               default: begin
               end
            endcase
            if (res_ready) begin
               count_in = res.live_count;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      hash_ff      <= hash_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      steps_ff     <= steps_in;
      free_vld_ff  <= free_vld_in;
      free_idx_ff  <= free_idx_in;
      hit_ff       <= hit_in;
      hit_value_ff <= hit_value_in;
   end

endmodule

>>> design/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Steps: accept in the idle state, then probe one slot per cycle through
// the registered slot memory read (no probe for an unknown command), then
// commit when the output register is free; the result beat is registered
// from the commit. A new request is taken only after the last one commits.
// Reset: synchronous; all slots read empty at once, live count is zero.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // key_hash[31:0], key_id[63:32], new_value[95:64]
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // read_value[31:0], live_count[37:32], zero[39:38]
   output logic [2:0]   rsp_tuser    // status[2:0]
);

   logic [lpht_pkg::IDX_W-1:0] rd_addr;
   lpht_pkg::wr_type           wr;
   lpht_pkg::slot_type         rd;
   logic                       res_valid;
   logic                       res_ready;
   lpht_pkg::res_type          res;
   logic                       rsp_valid_ff;
   lpht_pkg::res_type          rsp_ff;

   lpht_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd      (rd)
   );

   lpht_probe_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_hash  (req_tdata[31:0]),
      .req_key   (req_tdata[63:32]),
      .req_value (req_tdata[95:64]),
      .rd        (rd),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register: the sequencer commits only when this slot is free.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.live_count, rsp_ff.read_value};

endmodule

>>> design/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table unit, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // The live count never exceeds the number of slots.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:32] <= 6'(lpht_pkg::SLOTS))
      else $error("live count out of range");

   // Only a hit carries a value back.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != lpht_pkg::ST_FOUND |-> rsp_tdata[31:0] == 32'd0)
      else $error("read value nonzero without a hit");

   // An insert always leaves at least one live entry.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lpht_pkg::ST_INSERTED |-> rsp_tdata[37:32] != 6'd0)
      else $error("insert reported with zero live entries");

   // A result beat carries one of the defined status codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= lpht_pkg::ST_FULL)
      else $error("undefined status code");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
